FILE: design/iida_pkg.sv
// Package for the indexed insert/delete array: operation codes, status codes
// and the command that the control logic broadcasts to the row of cells.
// No dependencies.
`default_nettype none
package iida_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  // Widest index and length fields over the supported depth range (up to 1024).
  localparam int unsigned MAX_IW    = 10;
  localparam int unsigned MAX_LW    = 11;
  localparam int unsigned WORD_W    = 32;

  typedef enum logic [2:0] {
    MODE_READ   = 3'd0,
    MODE_WRITE  = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_RESIZE = 3'd4,
    MODE_CREATE = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_CLAMPED   = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_SATURATED = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_READ,
    OP_WRITE,
    OP_INSERT,
    OP_DELETE,
    OP_TRUNC,
    OP_CLEAR
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [MAX_IW-1:0]   pos;
    logic [MAX_LW-1:0]   new_len;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_OUT
  } fsm_e;

endpackage
`default_nettype wire

FILE: design/iida_cell.sv
// One storage cell of the array: holds a word and, on a command, keeps it,
// takes a neighbor's word, takes the new value or clears. Uses iida_pkg.
`default_nettype none
module iida_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        apply_i,
  input  iida_pkg::cell_cmd_t        cmd_i,
  input  wire [iida_pkg::WORD_W-1:0] value_i,
  input  wire [iida_pkg::WORD_W-1:0] left_i,
  input  wire [iida_pkg::WORD_W-1:0] right_i,
  output logic [iida_pkg::WORD_W-1:0] data_o,
  output logic [iida_pkg::WORD_W-1:0] rd_o
);
  import iida_pkg::*;

  localparam logic [MAX_IW-1:0] IDX_P = MAX_IW'(IDX);
  localparam logic [MAX_LW-1:0] IDX_L = MAX_LW'(IDX);

  logic [WORD_W-1:0] data_q, data_d;
  logic              eq_p, gt_p, ge_p;

  assign eq_p = (IDX_P == cmd_i.pos);
  assign gt_p = (IDX_P > cmd_i.pos);
  assign ge_p = eq_p | gt_p;

  always_comb begin
    data_d = data_q;
    if (apply_i) begin
      case (cmd_i.op)
        OP_WRITE:  if (eq_p) data_d = value_i;
        OP_INSERT: begin
          if (eq_p) data_d = value_i;
          else if (gt_p) data_d = left_i;
        end
        // Words past the length are zero, so the shift needs no upper bound.
        OP_DELETE: if (ge_p) data_d = right_i;
        OP_TRUNC:  if (IDX_L >= cmd_i.new_len) data_d = '0;
        OP_CLEAR:  data_d = '0;
        default:   data_d = data_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;
  assign rd_o   = (cmd_i.op == OP_READ && eq_p) ? data_q : '0;

endmodule
`default_nettype wire

FILE: design/indexed_insert_delete_array.sv
// Indexed insert/delete array: a row of DEPTH cells with a length register.
// Each request is decoded on acceptance, applied in the cell update, then held for the output handoff;
// no new request is taken until the result is handed off (out_ready_i), so requests do not overlap.
// The row of cells shifts all words at once, so latency does not grow with DEPTH.
// Reset clears every word and the length to zero; no clearing pass is needed.
// Uses iida_pkg and iida_cell.
`default_nettype none
module indexed_insert_delete_array #(
  parameter int unsigned DEPTH = iida_pkg::DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [2:0]  mode_i,
  input  wire  [31:0] position_i,
  input  wire  [31:0] value_i,
  input  wire  [31:0] new_length_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] read_value_o,
  output logic [6:0]  current_length_o,
  output logic [2:0]  status_o
);
  import iida_pkg::*;

  localparam int unsigned LW      = $clog2(DEPTH + 1);
  localparam logic [31:0] DEPTH32 = 32'(DEPTH);

  fsm_e              state_q, state_d;
  logic [LW-1:0]     len_q, len_d;
  cell_cmd_t         cmd_q, cmd_d;
  logic [WORD_W-1:0] value_q;
  status_e           status_q, status_d;
  logic [WORD_W-1:0] read_q;
  logic              accept;
  logic              apply;

  logic [31:0]       len32;
  logic [LW-1:0]     len_m1;
  logic              pos_neg, pos_ge_len, pos_gt_len, nl_neg, nl_big;

  logic [WORD_W-1:0] cell_data [DEPTH];
  logic [WORD_W-1:0] cell_rd   [DEPTH];
  logic [WORD_W-1:0] rd_or;

  assign accept     = in_valid_i & in_ready_o;
  assign apply      = (state_q == FSM_EXEC);
  assign len32      = 32'(len_q);
  assign len_m1     = len_q - LW'(1);
  assign pos_neg    = position_i[31];
  assign pos_ge_len = !pos_neg && (position_i >= len32);
  assign pos_gt_len = !pos_neg && (position_i > len32);
  assign nl_neg     = new_length_i[31];
  assign nl_big     = !nl_neg && (new_length_i > DEPTH32);

  // Decode the request against the current length.
  always_comb begin
    cmd_d.op      = OP_NONE;
    cmd_d.pos     = position_i[MAX_IW-1:0];
    cmd_d.new_len = new_length_i[MAX_LW-1:0];
    status_d      = ST_DONE;
    len_d         = len_q;
    case (mode_e'(mode_i))
      MODE_READ, MODE_WRITE: begin
        if (len_q == '0) begin
          status_d = (mode_e'(mode_i) == MODE_READ) ? ST_EMPTY : ST_IGNORED;
        end else begin
          cmd_d.op = (mode_e'(mode_i) == MODE_READ) ? OP_READ : OP_WRITE;
          if (pos_neg) begin
            cmd_d.pos = '0;
            status_d  = ST_CLAMPED;
          end else if (pos_ge_len) begin
            cmd_d.pos = MAX_IW'(len_m1);
            status_d  = ST_CLAMPED;
          end
        end
      end
      MODE_INSERT: begin
        if (len32 >= DEPTH32) begin
          status_d = ST_SATURATED;
        end else begin
          cmd_d.op = OP_INSERT;
          len_d    = len_q + LW'(1);
          if (pos_neg) begin
            cmd_d.pos = '0;
            status_d  = ST_CLAMPED;
          end else if (pos_gt_len) begin
            cmd_d.pos = MAX_IW'(len_q);
            status_d  = ST_CLAMPED;
          end
        end
      end
      MODE_DELETE: begin
        if (pos_neg || pos_ge_len) begin
          status_d = ST_IGNORED;
        end else begin
          cmd_d.op = OP_DELETE;
          len_d    = len_m1;
        end
      end
      MODE_RESIZE, MODE_CREATE: begin
        if (nl_neg) begin
          status_d = ST_IGNORED;
        end else begin
          cmd_d.op = (mode_e'(mode_i) == MODE_CREATE) ? OP_CLEAR : OP_TRUNC;
          if (nl_big) begin
            cmd_d.new_len = MAX_LW'(DEPTH);
            status_d      = ST_SATURATED;
          end
          len_d = LW'(cmd_d.new_len);
        end
      end
      default: status_d = ST_IGNORED;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (in_valid_i) state_d = FSM_EXEC;
      FSM_EXEC: state_d = FSM_OUT;
      FSM_OUT:  if (out_ready_i) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      len_q   <= '0;
      cmd_q   <= '{op: OP_NONE, pos: '0, new_len: '0};
    end else begin
      state_q <= state_d;
      if (accept) begin
        len_q <= len_d;
        cmd_q <= cmd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q  <= value_i;
      status_q <= status_d;
    end
    if (apply) begin
      read_q <= rd_or;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [WORD_W-1:0] left_w, right_w;
      if (gi == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_data[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_data[gi+1];
      end
      iida_cell #(
        .IDX (gi)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .apply_i (apply),
        .cmd_i   (cmd_q),
        .value_i (value_q),
        .left_i  (left_w),
        .right_i (right_w),
        .data_o  (cell_data[gi]),
        .rd_o    (cell_rd[gi])
      );
    end
  endgenerate

  // Only the addressed cell drives a nonzero read word.
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  assign in_ready_o       = (state_q == FSM_IDLE);
  assign out_valid_o      = (state_q == FSM_OUT);
  assign read_value_o     = read_q;
  assign current_length_o = 7'(len_q);
  assign status_o         = status_q;

endmodule
`default_nettype wire
